// ===== rtl/video_frame_loss_monitor_macros.svh =====
// Assertion macros shared by the loss monitor modules.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef VIDEO_FRAME_LOSS_MONITOR_MACROS_SVH
`define VIDEO_FRAME_LOSS_MONITOR_MACROS_SVH

`ifndef SYNTH

// Consequence must hold in the same cycle as the condition
`define VFLM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vflm: same-cycle check failed");

// Consequence must hold in the cycle after the condition
`define VFLM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vflm: next-cycle check failed");

`else

`define VFLM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VFLM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/vflm_pkg.sv =====
`timescale 1ns / 1ps

package vflm_pkg;

  localparam int FRAME_BITS = 24;
  localparam int SEQ_BITS   = 16;
  localparam int CNT_W      = 32;
  // Signed width of frame and encoding numbers: frame number plus one, plus sign
  localparam int ENC_W      = FRAME_BITS + 2;

  // Shared divider geometry
  localparam int DIV_W      = ENC_W;
  localparam int DIVR_W     = FRAME_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam logic [FRAME_BITS-1:0] LOST_MAX = '1;

  typedef logic signed [ENC_W-1:0] frame_t;

  typedef enum logic [1:0] {
    FT_I   = 2'd0,
    FT_IDR = 2'd1,
    FT_P   = 2'd2,
    FT_B   = 2'd3
  } frame_type_t;

  typedef enum logic [1:0] {
    CFG_B_FRAMES = 2'd0,
    CFG_GOP      = 2'd1,
    CFG_TRACE    = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ENC_GO,
    ST_ENC_WAIT,
    ST_SPAN_GO,
    ST_SPAN_WAIT,
    ST_GOP_GO,
    ST_GOP_WAIT,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [3:0]            b_frames;
    logic [7:0]            gop;
    logic [FRAME_BITS-1:0] trace;
  } cfg_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0]   seq;
    logic                  first;
    logic                  last;
    logic [FRAME_BITS-1:0] fn;
    frame_type_t           ftype;
    logic                  warm;
  } item_t;

  typedef struct packed {
    logic                  synced;
    logic [SEQ_BITS-1:0]   plost;
    logic [FRAME_BITS-1:0] flost;
    logic [CNT_W-1:0]      pkt_rx;
    logic [CNT_W-1:0]      pkt_lost;
    logic [CNT_W-1:0]      frm_rx;
    logic [CNT_W-1:0]      frm_disc;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVR_W-1:0] remainder;
  } div_rsp_t;

  // Encoding number of a frame from its display number and type
  function automatic frame_t encoding_of(logic [FRAME_BITS-1:0] fn, logic [3:0] nb,
                                         frame_type_t ft);
    frame_t fn_s;
    frame_t nb_s;
    fn_s = $signed({2'b00, fn});
    nb_s = $signed({{(ENC_W-4){1'b0}}, nb});
    if (ft == FT_B) begin
      return fn_s + frame_t'(1);
    end else if (ft == FT_P) begin
      return fn_s - nb_s;
    end else if (fn == '0) begin
      return '0;
    end else begin
      return fn_s - nb_s;
    end
  endfunction

endpackage

// ===== rtl/vflm_divider.sv =====
`timescale 1ns / 1ps
`include "video_frame_loss_monitor_macros.svh"

// Radix-2 restoring divider, one quotient bit per cycle; only the remainder is used
module vflm_divider (
  input  logic               clk,
  input  logic               rst,
  input  vflm_pkg::div_req_t req,
  output vflm_pkg::div_rsp_t rsp
);

  logic [vflm_pkg::DIVR_W:0]    rem;
  logic [vflm_pkg::DIV_W-1:0]   quo;
  logic [vflm_pkg::DIVR_W-1:0]  dsr;
  logic [vflm_pkg::DIV_CNT_W-1:0] cnt;
  logic                         busy;
  logic                         done;
  logic [vflm_pkg::DIVR_W:0]    trial;
  logic                         ge;
  logic [vflm_pkg::DIVR_W:0]    rem_step;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial    = {rem[vflm_pkg::DIVR_W-1:0], quo[vflm_pkg::DIV_W-1]};
    ge       = trial >= {1'b0, dsr};
    rem_step = ge ? (trial - {1'b0, dsr}) : trial;
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == vflm_pkg::DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance the partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_step;
      quo <= {quo[vflm_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.remainder = rem[vflm_pkg::DIVR_W-1:0];

  `VFLM_ASSERT_IMP(a_start_when_idle, clk, rst, req.start, !busy)
  `VFLM_ASSERT_NXT(a_start_goes_busy, clk, rst, req.start, busy)
  `VFLM_ASSERT_IMP(a_done_after_busy, clk, rst, done, !busy)

endmodule

// ===== rtl/vflm_core.sv =====
`timescale 1ns / 1ps
`include "video_frame_loss_monitor_macros.svh"

// Sequencer and loss tracking state; drives the shared divider
module vflm_core (
  input  logic               clk,
  input  logic               rst,
  input  vflm_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  vflm_pkg::item_t    in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output vflm_pkg::res_t     res,
  output vflm_pkg::div_req_t div_req,
  input  vflm_pkg::div_rsp_t div_rsp
);

  vflm_pkg::state_t state, state_next;
  vflm_pkg::item_t  item;

  // Tracking state
  logic                              locked, locked_next;
  logic [vflm_pkg::SEQ_BITS-1:0]     last_seq, last_seq_next;
  vflm_pkg::frame_t                  lgi, lgi_next;
  vflm_pkg::frame_t                  lgp, lgp_next;
  logic [vflm_pkg::FRAME_BITS-1:0]   open_fn, open_fn_next;
  vflm_pkg::frame_t                  open_enc, open_enc_next;
  logic                              open_done, open_done_next;
  logic                              open_drop, open_drop_next;
  logic [vflm_pkg::CNT_W-1:0]        pkt_rx, pkt_rx_next;
  logic [vflm_pkg::CNT_W-1:0]        pkt_lost, pkt_lost_next;
  logic [vflm_pkg::CNT_W-1:0]        frm_rx, frm_rx_next;
  logic [vflm_pkg::CNT_W-1:0]        frm_disc, frm_disc_next;

  // Division results
  vflm_pkg::frame_t                  nxt_reg;
  logic [vflm_pkg::FRAME_BITS-1:0]   prevref;
  logic                              gop_hit;

  logic                              res_valid;
  logic                              commit;

  // Derived values of the held word
  vflm_pkg::frame_t                  enc;
  vflm_pkg::frame_t                  fn_s;
  vflm_pkg::frame_t                  nb_s;
  vflm_pkg::frame_t                  nxt_raw;
  vflm_pkg::frame_t                  nxt_v;
  logic                              nxt_neg;
  logic [vflm_pkg::DIV_W-1:0]        nxt_mag;
  logic [4:0]                        span;
  logic [vflm_pkg::FRAME_BITS:0]     nextref;
  vflm_pkg::frame_t                  nextref_s;
  vflm_pkg::frame_t                  prevref_s;
  vflm_pkg::frame_t                  p_ref;
  vflm_pkg::frame_t                  enc_max;
  logic                              is_ref_i;
  logic                              is_b;
  logic                              lock_hit;
  logic                              gap;
  logic [vflm_pkg::SEQ_BITS-1:0]     plost_v;
  logic                              dropped_mid;
  logic                              pass;
  logic                              tail_inc;
  logic signed [vflm_pkg::ENC_W:0]   flost_sum;
  logic [vflm_pkg::FRAME_BITS-1:0]   flost_v;

  always_comb begin
    enc       = vflm_pkg::encoding_of(item.fn, cfg.b_frames, item.ftype);
    fn_s      = $signed({2'b00, item.fn});
    nb_s      = $signed({{(vflm_pkg::ENC_W-4){1'b0}}, cfg.b_frames});
    nxt_raw   = open_enc + vflm_pkg::frame_t'(1);
    nxt_neg   = nxt_raw[vflm_pkg::ENC_W-1];
    nxt_mag   = nxt_neg ? vflm_pkg::DIV_W'(-nxt_raw) : vflm_pkg::DIV_W'(nxt_raw);
    nxt_v     = (cfg.trace == '0) ? nxt_raw : nxt_reg;
    span      = {1'b0, cfg.b_frames} + 5'd1;
    nextref   = {1'b0, prevref} + {{(vflm_pkg::FRAME_BITS-4){1'b0}}, span};
    nextref_s = $signed({1'b0, nextref});
    prevref_s = $signed({2'b00, prevref});
    p_ref     = fn_s - nb_s - vflm_pkg::frame_t'(1);
    enc_max   = (enc > open_enc) ? enc : open_enc;
    is_ref_i  = (item.ftype == vflm_pkg::FT_I) || (item.ftype == vflm_pkg::FT_IDR);
    is_b      = item.ftype == vflm_pkg::FT_B;
    lock_hit  = item.warm && is_ref_i && item.first;
    gap       = item.seq != (last_seq + 1'b1);
    plost_v   = (item.seq > last_seq) ? (item.seq - last_seq) : vflm_pkg::SEQ_BITS'(1);
    dropped_mid = open_drop | (gap & !item.first);
  end

  // Reference check of the frame that starts with this word
  always_comb begin
    if (is_ref_i) begin
      pass = 1'b1;
    end else if (item.ftype == vflm_pkg::FT_P) begin
      pass = (lgi == p_ref) || (lgp == p_ref);
    end else if ((cfg.gop != '0) && gop_hit) begin
      pass = (lgp == prevref_s) && (lgi == nextref_s);
    end else begin
      pass = lgp == nextref_s;
    end
  end

  // Frames lost at this word, clamped to the field range
  always_comb begin
    tail_inc  = item.first ? (!pass && item.last) : (item.last && dropped_mid);
    flost_sum = '0;
    if (gap && (enc > nxt_v)) begin
      flost_sum = {enc_max[vflm_pkg::ENC_W-1], enc_max}
                - {open_enc[vflm_pkg::ENC_W-1], open_enc}
                - (vflm_pkg::ENC_W+1)'(1);
    end
    flost_sum = flost_sum + $signed({{vflm_pkg::ENC_W{1'b0}}, gap && !open_done})
                          + $signed({{vflm_pkg::ENC_W{1'b0}}, tail_inc});
    if (flost_sum < 0) begin
      flost_v = '0;
    end else if (flost_sum > $signed({3'b000, vflm_pkg::LOST_MAX})) begin
      flost_v = vflm_pkg::LOST_MAX;
    end else begin
      flost_v = flost_sum[vflm_pkg::FRAME_BITS-1:0];
    end
  end

  // Next tracking state for the word being finished
  always_comb begin
    locked_next    = locked;
    last_seq_next  = last_seq;
    lgi_next       = lgi;
    lgp_next       = lgp;
    open_fn_next   = open_fn;
    open_enc_next  = open_enc;
    open_done_next = open_done;
    open_drop_next = open_drop;
    pkt_rx_next    = pkt_rx;
    pkt_lost_next  = pkt_lost;
    frm_rx_next    = frm_rx;
    frm_disc_next  = frm_disc;
    if (!locked) begin
      if (lock_hit) begin
        last_seq_next = item.seq;
        lgp_next      = (item.fn != '0) ? p_ref : '1;
        open_fn_next  = item.fn;
        open_enc_next = enc;
        if (item.last) begin
          open_done_next = 1'b1;
          lgi_next       = fn_s;
          frm_rx_next    = frm_rx + 1'b1;
        end else begin
          open_drop_next = 1'b0;
          open_done_next = 1'b0;
          lgi_next       = '1;
        end
        pkt_rx_next = pkt_rx + 1'b1;
        locked_next = 1'b1;
      end
    end else begin
      last_seq_next  = item.seq;
      open_drop_next = dropped_mid;
      if (item.first) begin
        if (pass) begin
          if ((item.ftype == vflm_pkg::FT_P) || !item.last) begin
            open_drop_next = 1'b0;
          end
          if (item.last) begin
            if (item.ftype == vflm_pkg::FT_P) begin
              lgp_next = fn_s;
            end else if (!is_b) begin
              lgi_next = fn_s;
            end
            frm_rx_next = frm_rx + 1'b1;
          end
        end else begin
          open_drop_next = 1'b1;
        end
        open_done_next = item.last;
        open_fn_next   = item.fn;
        open_enc_next  = enc;
      end else if (item.last) begin
        if (!dropped_mid) begin
          if (item.ftype == vflm_pkg::FT_P) begin
            lgp_next = $signed({2'b00, open_fn});
          end else if (!is_b) begin
            lgi_next = $signed({2'b00, open_fn});
          end
          frm_rx_next = frm_rx + 1'b1;
        end
        open_done_next = 1'b1;
      end
      pkt_rx_next   = pkt_rx + 1'b1;
      pkt_lost_next = pkt_lost + (gap ? {{(vflm_pkg::CNT_W-vflm_pkg::SEQ_BITS){1'b0}}, plost_v}
                                      : '0);
      frm_disc_next = frm_disc + {{(vflm_pkg::CNT_W-vflm_pkg::FRAME_BITS){1'b0}}, flost_v};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      vflm_pkg::ST_IDLE: begin
        if (in_valid) state_next = vflm_pkg::ST_DECIDE;
      end
      vflm_pkg::ST_DECIDE: begin
        if (!locked) begin
          state_next = vflm_pkg::ST_APPLY;
        end else if (gap && (cfg.trace != '0)) begin
          state_next = vflm_pkg::ST_ENC_GO;
        end else if (item.first && is_b) begin
          state_next = vflm_pkg::ST_SPAN_GO;
        end else begin
          state_next = vflm_pkg::ST_APPLY;
        end
      end
      vflm_pkg::ST_ENC_GO:   state_next = vflm_pkg::ST_ENC_WAIT;
      vflm_pkg::ST_ENC_WAIT: begin
        if (div_rsp.done) begin
          state_next = (item.first && is_b) ? vflm_pkg::ST_SPAN_GO : vflm_pkg::ST_APPLY;
        end
      end
      vflm_pkg::ST_SPAN_GO:   state_next = vflm_pkg::ST_SPAN_WAIT;
      vflm_pkg::ST_SPAN_WAIT: begin
        if (div_rsp.done) begin
          state_next = (cfg.gop != '0) ? vflm_pkg::ST_GOP_GO : vflm_pkg::ST_APPLY;
        end
      end
      vflm_pkg::ST_GOP_GO:   state_next = vflm_pkg::ST_GOP_WAIT;
      vflm_pkg::ST_GOP_WAIT: begin
        if (div_rsp.done) state_next = vflm_pkg::ST_APPLY;
      end
      vflm_pkg::ST_APPLY: begin
        if (commit) state_next = vflm_pkg::ST_IDLE;
      end
      default: state_next = vflm_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake, commit and divider operands
  always_comb begin
    in_ready         = state == vflm_pkg::ST_IDLE;
    commit           = (state == vflm_pkg::ST_APPLY) && (!res_valid || out_ready);
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      vflm_pkg::ST_ENC_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = nxt_mag;
        div_req.divisor  = cfg.trace;
      end
      vflm_pkg::ST_SPAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {2'b00, item.fn};
        div_req.divisor  = {{(vflm_pkg::DIVR_W-5){1'b0}}, span};
      end
      vflm_pkg::ST_GOP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, nextref};
        div_req.divisor  = {{(vflm_pkg::DIVR_W-8){1'b0}}, cfg.gop};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vflm_pkg::ST_IDLE;
      res_valid <= 1'b0;
      locked    <= 1'b0;
      last_seq  <= '0;
      lgi       <= '1;
      lgp       <= '1;
      open_fn   <= '0;
      open_enc  <= '0;
      open_done <= 1'b1;
      open_drop <= 1'b0;
      pkt_rx    <= '0;
      pkt_lost  <= '0;
      frm_rx    <= '0;
      frm_disc  <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        res_valid <= 1'b1;
        locked    <= locked_next;
        last_seq  <= last_seq_next;
        lgi       <= lgi_next;
        lgp       <= lgp_next;
        open_fn   <= open_fn_next;
        open_enc  <= open_enc_next;
        open_done <= open_done_next;
        open_drop <= open_drop_next;
        pkt_rx    <= pkt_rx_next;
        pkt_lost  <= pkt_lost_next;
        frm_rx    <= frm_rx_next;
        frm_disc  <= frm_disc_next;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Hold the input word and capture divider results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_item;
    if ((state == vflm_pkg::ST_ENC_WAIT) && div_rsp.done) begin
      nxt_reg <= nxt_neg ? -$signed({2'b00, div_rsp.remainder})
                         :  $signed({2'b00, div_rsp.remainder});
    end
    if ((state == vflm_pkg::ST_SPAN_WAIT) && div_rsp.done) begin
      prevref <= item.fn - div_rsp.remainder;
    end
    if ((state == vflm_pkg::ST_GOP_WAIT) && div_rsp.done) begin
      gop_hit <= div_rsp.remainder == '0;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (commit) begin
      res.synced   <= locked_next;
      res.plost    <= (locked && gap) ? plost_v : '0;
      res.flost    <= locked ? flost_v : '0;
      res.pkt_rx   <= pkt_rx_next;
      res.pkt_lost <= pkt_lost_next;
      res.frm_rx   <= frm_rx_next;
      res.frm_disc <= frm_disc_next;
    end
  end

  assign out_valid = res_valid;

  `VFLM_ASSERT_NXT(a_lock_sticks, clk, rst, locked, locked)
  `VFLM_ASSERT_IMP(a_sync_tracks_lock, clk, rst, res_valid, res.synced == locked)
  `VFLM_ASSERT_IMP(a_div_start_state, clk, rst, div_req.start, state == vflm_pkg::ST_ENC_GO || state == vflm_pkg::ST_SPAN_GO || state == vflm_pkg::ST_GOP_GO)

endmodule

// ===== rtl/video_frame_loss_monitor.sv =====
`timescale 1ns / 1ps

// Receive-side video loss monitor. Each input word is one packet header; each
// produces exactly one result word with the lock flag, the packets and frames
// found lost at that packet and the four wrapping 32-bit totals. The block
// takes one word at a time: s_tready is high only while it is idle, and a new
// word may be taken while the previous result waits on the output register.
// A word uses the shared 26-step remainder unit once for a sequence gap with
// a non-zero encoding modulus, and twice more (once when gop_length is zero)
// for the first fragment of a B frame. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must keep to writing it while no
// word is in flight, and the block itself does not enforce this.
module video_frame_loss_monitor (
  input  logic         clk,
  input  logic         rst,
  // Configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  // Packet headers
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // seq_number[15:0], frame_number[39:16], warmup_over[40]
  input  logic [2:0]   s_tuser,   // fragment_first[0], frame_type[2:1]
  input  logic         s_tlast,   // fragment_last
  // Results
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata    // synced[0], packets_lost_now[16:1],
                                  // frames_lost_now[40:17],
                                  // total_packets_received[72:41],
                                  // total_packets_lost[104:73],
                                  // total_frames_received[136:105],
                                  // total_frames_discarded[168:137]
);

  vflm_pkg::cfg_t     cfg;
  vflm_pkg::item_t    in_item;
  vflm_pkg::res_t     res;
  vflm_pkg::div_req_t div_req;
  vflm_pkg::div_rsp_t div_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b_frames <= 4'd2;
      cfg.gop      <= 8'd12;
      cfg.trace    <= '1;
    end else if (cfg_we) begin
      unique case (vflm_pkg::cfg_index_t'(cfg_index))
        vflm_pkg::CFG_B_FRAMES: cfg.b_frames <= cfg_data[3:0];
        vflm_pkg::CFG_GOP:      cfg.gop      <= cfg_data[7:0];
        vflm_pkg::CFG_TRACE:    cfg.trace    <= cfg_data;
        default:                cfg.trace    <= cfg.trace;
      endcase
    end
  end

  // Unpack the input word
  always_comb begin
    in_item.seq   = s_tdata[15:0];
    in_item.first = s_tuser[0];
    in_item.last  = s_tlast;
    in_item.fn    = s_tdata[39:16];
    in_item.ftype = vflm_pkg::frame_type_t'(s_tuser[2:1]);
    in_item.warm  = s_tdata[40];
  end

  vflm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  vflm_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Pack the result word
  assign m_tdata = {7'd0, res.frm_disc, res.frm_rx, res.pkt_lost, res.pkt_rx,
                    res.flost, res.plost, res.synced};

endmodule
